FILE: rtl/u2u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
`default_nettype none
package u2u8_pkg;

  localparam int unsigned MAX_BYTES = 6;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [5:0]  LEAD_TAG  = 6'b110110;
  localparam logic [5:0]  TRAIL_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [15:0] LIMIT_ONE = 16'h0080;
  localparam logic [15:0] LIMIT_TWO = 16'h0800;

  localparam logic [7:0] HDR_TWO   = 8'hC0;
  localparam logic [7:0] HDR_THREE = 8'hE0;
  localparam logic [7:0] HDR_FOUR  = 8'hF0;
  localparam logic [7:0] HDR_CONT  = 8'h80;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [MAX_BYTES-1:0]      repl;
    logic [2:0]                cnt;
    logic                      at_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: rtl/u2u8_if.sv
// Channel interfaces for code units in and UTF-8 bytes out.
`timescale 1ns / 1ps
`default_nettype none
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink (input valid, input code_unit, input string_end, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       replaced;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output replaced,
                  output text_done, input ready);
  modport sink (input valid, input out_byte, input run_last, input replaced,
                input text_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/u2u8_front.sv
// Front end: accepts code units, tracks the held lead and builds byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  u2u8_in_if.sink                 in_ch,
  input  wire u2u8_pkg::q_status_t q_status,
  output logic                    push,
  output u2u8_pkg::job_t          push_job
);
  import u2u8_pkg::*;

  logic        lead_r, lead_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        accept;
  logic [15:0] cu;
  logic        at_end;
  logic        is_lead;
  logic        is_trail;
  logic        pair;
  logic [20:0] code;
  logic [2:0][7:0] u_bytes;
  logic [1:0]  u_cnt;
  logic        u_repl;
  job_t        job;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cu          = in_ch.code_unit;
  assign at_end      = in_ch.string_end;
  assign is_lead     = (cu[15:10] == LEAD_TAG);
  assign is_trail    = (cu[15:10] == TRAIL_TAG);
  assign pair        = lead_r && is_trail;
  assign code        = SUPP_BASE + {1'b0, held_r, cu[9:0]};

  always_comb begin
    u_bytes = '0;
    u_cnt   = 2'd0;
    u_repl  = 1'b0;
    if (cu < LIMIT_ONE) begin
      u_bytes[0] = {1'b0, cu[6:0]};
      u_cnt      = 2'd1;
    end else if (cu < LIMIT_TWO) begin
      u_bytes[0] = HDR_TWO | {3'b000, cu[10:6]};
      u_bytes[1] = HDR_CONT | {2'b00, cu[5:0]};
      u_cnt      = 2'd2;
    end else if (is_lead) begin
      if (at_end) begin
        u_bytes = {REPL_B2, REPL_B1, REPL_B0};
        u_cnt   = 2'd3;
        u_repl  = 1'b1;
      end
    end else if (is_trail) begin
      u_bytes = {REPL_B2, REPL_B1, REPL_B0};
      u_cnt   = 2'd3;
      u_repl  = 1'b1;
    end else begin
      u_bytes[0] = HDR_THREE | {4'b0000, cu[15:12]};
      u_bytes[1] = HDR_CONT | {2'b00, cu[11:6]};
      u_bytes[2] = HDR_CONT | {2'b00, cu[5:0]};
      u_cnt      = 2'd3;
    end
  end

  always_comb begin
    job        = '0;
    job.at_end = at_end;
    if (pair) begin
      job.bytes[0] = HDR_FOUR | {5'b00000, code[20:18]};
      job.bytes[1] = HDR_CONT | {2'b00, code[17:12]};
      job.bytes[2] = HDR_CONT | {2'b00, code[11:6]};
      job.bytes[3] = HDR_CONT | {2'b00, code[5:0]};
      job.cnt      = 3'd4;
    end else if (lead_r) begin
      job.bytes[0] = REPL_B0;
      job.bytes[1] = REPL_B1;
      job.bytes[2] = REPL_B2;
      job.bytes[3] = u_bytes[0];
      job.bytes[4] = u_bytes[1];
      job.bytes[5] = u_bytes[2];
      job.repl     = {{3{u_repl}}, 3'b111};
      job.cnt      = 3'd3 + {1'b0, u_cnt};
    end else begin
      job.bytes[0] = u_bytes[0];
      job.bytes[1] = u_bytes[1];
      job.bytes[2] = u_bytes[2];
      job.repl     = {3'b000, {3{u_repl}}};
      job.cnt      = {1'b0, u_cnt};
    end
  end

  assign push     = accept && (job.cnt != 3'd0);
  assign push_job = job;

  always_comb begin
    lead_nxt = lead_r;
    held_nxt = held_r;
    if (accept) begin
      lead_nxt = is_lead && !at_end;
      held_nxt = (is_lead && !at_end) ? cu[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 1'b0;
      held_r <= 10'd0;
    end else begin
      lead_r <= lead_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/u2u8_queue.sv
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire u2u8_pkg::job_t      push_job,
  input  wire logic                pop,
  output u2u8_pkg::job_t           head_job,
  output u2u8_pkg::q_status_t      status
);
  import u2u8_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/u2u8_back.sv
// Back end: serializes queued jobs into one UTF-8 byte per word.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u2u8_pkg::job_t      head_job,
  input  wire u2u8_pkg::q_status_t q_status,
  output logic                     pop,
  u2u8_out_if.source               out_ch
);
  import u2u8_pkg::*;

  logic       idx_r, idx_unused;
  logic [2:0] pos_r, pos_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       repl_r, repl_nxt;
  logic       done_r, done_nxt;
  logic       load;
  logic       have;
  logic       is_last;

  assign idx_unused = 1'b0;
  assign have    = !q_status.empty;
  assign load    = !vld_r || out_ch.ready;
  assign is_last = (pos_r == head_job.cnt - 3'd1);
  assign pop     = load && have && is_last;

  always_comb begin
    pos_nxt  = pos_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    repl_nxt = repl_r;
    done_nxt = done_r;
    if (load) begin
      vld_nxt = have;
      if (have) begin
        byte_nxt = head_job.bytes[pos_r];
        repl_nxt = head_job.repl[pos_r];
        last_nxt = is_last;
        done_nxt = is_last && head_job.at_end;
        pos_nxt  = is_last ? 3'd0 : pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      vld_r <= 1'b0;
      idx_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
      idx_r <= idx_unused;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    repl_r <= repl_nxt;
    done_r <= done_nxt;
  end

  assign out_ch.valid     = vld_r && !idx_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.run_last  = last_r;
  assign out_ch.replaced  = repl_r;
  assign out_ch.text_done = done_r;

endmodule
`default_nettype wire

FILE: rtl/utf16_to_utf8_encoder_core.sv
// Top level of the UTF-16 to UTF-8 encoder.
// The first byte of a code unit passes the job queue and then the output register.
// Throughput: one output byte per cycle while the output is ready; a unit causes one to
// six bytes (usually up to three), sent one at a time through the single-byte output register.
// A held lead surrogate that causes no byte pushes no job into the queue.
// Reset (synchronous, active low) drops any held lead and empties the job queue.
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u2u8_in_if.sink    in_ch,
  u2u8_out_if.source out_ch
);
  import u2u8_pkg::*;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_status;

  u2u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  u2u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/u2u8_checker.sv
// Port-level checks for the encoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last,
  input wire logic       out_replaced,
  input wire logic       out_text_done
);
  import u2u8_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled word changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_run_last)
    else $error("string end off the last byte of a unit");

  a_repl_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced && out_run_last |-> out_byte == REPL_B2)
    else $error("replacement sequence ends on a wrong byte");

  a_no_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last && !out_replaced |-> out_byte[7:6] != 2'b11)
    else $error("unit ends on a sequence header byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf16_to_utf8_encoder_core u2u8_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .out_run_last  (out_ch.run_last),
  .out_replaced  (out_ch.replaced),
  .out_text_done (out_ch.text_done)
);
`default_nettype wire
